// ----- src/magenta_feistel_encrypt_unit_defines.svh -----
// Assertion macros used by the checker file of the MAGENTA encrypt unit
`ifndef MAGENTA_FEISTEL_ENCRYPT_UNIT_DEFINES_SVH
`define MAGENTA_FEISTEL_ENCRYPT_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define MFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define MFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define MFE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/mfe_pkg.sv -----
// Types, constants and round-function helpers of the MAGENTA encrypt unit
package mfe_pkg;

   localparam int HALF_W           = 64;
   localparam int KEY_W            = 64;
   localparam int NUM_KEYS         = 8;
   localparam int KEY_SEL_W        = 3;
   localparam int CSR_IDX_W        = 4;
   localparam int NUM_BYTES        = 16;
   localparam int STAGES_PER_ROUND = 6;
   localparam int ROUNDS_DEFAULT   = 6;

   typedef logic [NUM_BYTES-1:0][7:0] bytes_type;
   typedef logic [NUM_KEYS-1:0][KEY_W-1:0] key_bank_type;

   typedef struct packed {
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
      bytes_type         t;
   } stage_data_type;

   typedef logic [7:0] exp_tab_type [256];

   // powers of alpha modulo 0x165, last entry forced to zero
   localparam exp_tab_type EXP_TAB = '{
      8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128,
      8'd101, 8'd202, 8'd241, 8'd135, 8'd107, 8'd214, 8'd201, 8'd247,
      8'd139, 8'd115, 8'd230, 8'd169, 8'd55,  8'd110, 8'd220, 8'd221,
      8'd223, 8'd219, 8'd211, 8'd195, 8'd227, 8'd163, 8'd35,  8'd70,
      8'd140, 8'd125, 8'd250, 8'd145, 8'd71,  8'd142, 8'd121, 8'd242,
      8'd129, 8'd103, 8'd206, 8'd249, 8'd151, 8'd75,  8'd150, 8'd73,
      8'd146, 8'd65,  8'd130, 8'd97,  8'd194, 8'd225, 8'd167, 8'd43,
      8'd86,  8'd172, 8'd61,  8'd122, 8'd244, 8'd141, 8'd127, 8'd254,
      8'd153, 8'd87,  8'd174, 8'd57,  8'd114, 8'd228, 8'd173, 8'd63,
      8'd126, 8'd252, 8'd157, 8'd95,  8'd190, 8'd25,  8'd50,  8'd100,
      8'd200, 8'd245, 8'd143, 8'd123, 8'd246, 8'd137, 8'd119, 8'd238,
      8'd185, 8'd23,  8'd46,  8'd92,  8'd184, 8'd21,  8'd42,  8'd84,
      8'd168, 8'd53,  8'd106, 8'd212, 8'd205, 8'd255, 8'd155, 8'd83,
      8'd166, 8'd41,  8'd82,  8'd164, 8'd45,  8'd90,  8'd180, 8'd13,
      8'd26,  8'd52,  8'd104, 8'd208, 8'd197, 8'd239, 8'd187, 8'd19,
      8'd38,  8'd76,  8'd152, 8'd85,  8'd170, 8'd49,  8'd98,  8'd196,
      8'd237, 8'd191, 8'd27,  8'd54,  8'd108, 8'd216, 8'd213, 8'd207,
      8'd251, 8'd147, 8'd67,  8'd134, 8'd105, 8'd210, 8'd193, 8'd231,
      8'd171, 8'd51,  8'd102, 8'd204, 8'd253, 8'd159, 8'd91,  8'd182,
      8'd9,   8'd18,  8'd36,  8'd72,  8'd144, 8'd69,  8'd138, 8'd113,
      8'd226, 8'd161, 8'd39,  8'd78,  8'd156, 8'd93,  8'd186, 8'd17,
      8'd34,  8'd68,  8'd136, 8'd117, 8'd234, 8'd177, 8'd7,   8'd14,
      8'd28,  8'd56,  8'd112, 8'd224, 8'd165, 8'd47,  8'd94,  8'd188,
      8'd29,  8'd58,  8'd116, 8'd232, 8'd181, 8'd15,  8'd30,  8'd60,
      8'd120, 8'd240, 8'd133, 8'd111, 8'd222, 8'd217, 8'd215, 8'd203,
      8'd243, 8'd131, 8'd99,  8'd198, 8'd233, 8'd183, 8'd11,  8'd22,
      8'd44,  8'd88,  8'd176, 8'd5,   8'd10,  8'd20,  8'd40,  8'd80,
      8'd160, 8'd37,  8'd74,  8'd148, 8'd77,  8'd154, 8'd81,  8'd162,
      8'd33,  8'd66,  8'd132, 8'd109, 8'd218, 8'd209, 8'd199, 8'd235,
      8'd179, 8'd3,   8'd6,   8'd12,  8'd24,  8'd48,  8'd96,  8'd192,
      8'd229, 8'd175, 8'd59,  8'd118, 8'd236, 8'd189, 8'd31,  8'd62,
      8'd124, 8'd248, 8'd149, 8'd79,  8'd158, 8'd89,  8'd178, 8'd0
   };

   function automatic logic [7:0] mix(input logic [7:0] x, input logic [7:0] y);
      return EXP_TAB[x ^ EXP_TAB[y]];
   endfunction

   // one butterfly level across index bit 'stride'
   function automatic bytes_type bfly_level(input bytes_type v, input int stride);
      bytes_type r;
      r = v;
      for (int i = 0; i < NUM_BYTES; i++) begin
         if ((i & stride) == 0) begin
            r[i]          = mix(v[i], v[i + stride]);
            r[i + stride] = mix(v[i + stride], v[i]);
         end
      end
      return r;
   endfunction

   // right half in bytes 0..7 and key in bytes 8..15, most significant first
   function automatic bytes_type unpack_bytes(input logic [HALF_W-1:0] r,
                                              input logic [KEY_W-1:0] k);
      bytes_type w;
      for (int j = 0; j < 8; j++) begin
         w[j]     = r[HALF_W-1-8*j -: 8];
         w[8 + j] = k[KEY_W-1-8*j -: 8];
      end
      return w;
   endfunction

   // even bytes, then odd bytes, xor the unpacked input
   function automatic bytes_type shuffle(input bytes_type w, input bytes_type t);
      bytes_type s;
      for (int i = 0; i < 8; i++) begin
         s[i]     = w[i] ^ t[2*i];
         s[i + 8] = w[i + 8] ^ t[2*i + 1];
      end
      return s;
   endfunction

   function automatic logic [HALF_W-1:0] even_bytes(input bytes_type t);
      logic [HALF_W-1:0] r;
      for (int j = 0; j < 8; j++) begin
         r[HALF_W-1-8*j -: 8] = t[2*j];
      end
      return r;
   endfunction

endpackage

// ----- src/mfe_key_regs.sv -----
// Round key register bank written through the configuration port
module mfe_key_regs
   import mfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata,
   output key_bank_type         keys
);

   key_bank_type key_ff;
   key_bank_type key_in;

   always_comb begin
      key_in = key_ff;
      // drop writes beyond the last key
      if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_KEYS))) begin
         key_in[csr_index[KEY_SEL_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign keys = key_ff;

endmodule

// ----- src/mfe_stage.sv -----
// One pipeline stage: two butterfly levels of a round function pass
module mfe_stage
   import mfe_pkg::*;
#(
   parameter int SUB = 0
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  stage_data_type up_data,
   input  logic [KEY_W-1:0] key,
   output logic           dn_valid,
   input  logic           dn_ready,
   output stage_data_type dn_data
);

   localparam int STRIDE_HI = ((SUB % 2) == 0) ? 8 : 2;
   localparam int STRIDE_LO = STRIDE_HI / 2;

   logic           valid_ff;
   logic           valid_in;
   stage_data_type data_ff;
   stage_data_type data_in;
   stage_data_type result;
   bytes_type      w;
   bytes_type      t0;
   bytes_type      t1;

   always_comb begin
      w = unpack_bytes(up_data.right, key);
      case (SUB)
         0:       t0 = w;
         2, 4:    t0 = shuffle(w, up_data.t);
         default: t0 = up_data.t;
      endcase
      t1 = bfly_level(bfly_level(t0, STRIDE_HI), STRIDE_LO);

      result.t = t1;
      if (SUB == STAGES_PER_ROUND - 1) begin
         // close the round: swap halves and fold in F
         result.left  = up_data.right;
         result.right = up_data.left ^ even_bytes(t1);
      end else begin
         result.left  = up_data.left;
         result.right = up_data.right;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      data_in  = (up_ready && up_valid) ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- src/magenta_feistel_encrypt_unit.sv -----
// Top level of the MAGENTA Feistel encrypt unit: key bank and round pipeline
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | req_tdata: left_half, right_half
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: left_result, right_result
//  csr     | in        | csr_wr_en              | csr_index, csr_wdata (round keys)
//
// Accepts one block per cycle while the output is not stalled; one stage per
// two butterfly levels of the fully unrolled round pipeline.
// Synchronous active-high reset clears the key bank and all stage valid bits.
// Each stage holds its item while the next one is full and stalled; empty
// stages still take data, so bubbles close up behind a stalled output.
module magenta_feistel_encrypt_unit
   import mfe_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*HALF_W-1:0]    req_tdata,   // left_half, right_half
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2*HALF_W-1:0]    rsp_tdata,   // left_result, right_result
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [KEY_W-1:0]       csr_wdata
);

   localparam int NSTAGE = ROUNDS * STAGES_PER_ROUND;

   key_bank_type   keys;
   logic           vld [NSTAGE+1];
   logic           rdy [NSTAGE+1];
   stage_data_type dat [NSTAGE+1];

   mfe_key_regs u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .keys      (keys)
   );

   assign vld[0]       = req_tvalid;
   assign req_tready   = rdy[0];
   assign dat[0].left  = req_tdata[HALF_W-1:0];
   assign dat[0].right = req_tdata[2*HALF_W-1:HALF_W];
   assign dat[0].t     = '0;

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int RND     = s / STAGES_PER_ROUND;
      localparam int KEY_SEL = RND % NUM_KEYS;

      mfe_stage #(
         .SUB (s % STAGES_PER_ROUND)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld[s]),
         .up_ready (rdy[s]),
         .up_data  (dat[s]),
         .key      (keys[KEY_SEL]),
         .dn_valid (vld[s+1]),
         .dn_ready (rdy[s+1]),
         .dn_data  (dat[s+1])
      );
   end

   assign rdy[NSTAGE] = rsp_tready;
   assign rsp_tvalid  = vld[NSTAGE];
   assign rsp_tdata   = {dat[NSTAGE].right, dat[NSTAGE].left};

endmodule

// ----- src/mfe_checker.sv -----
// Port-level checker for the MAGENTA encrypt unit, bound to the top level
`include "magenta_feistel_encrypt_unit_defines.svh"

module mfe_checker
   import mfe_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [2*HALF_W-1:0]  req_tdata,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [2*HALF_W-1:0]  rsp_tdata,
   input logic                 csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [KEY_W-1:0]     csr_wdata
);

   localparam int DEPTH = ROUNDS * STAGES_PER_ROUND;
   localparam int CNT_W = $clog2(DEPTH + 2);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             in_xfer;
   logic             out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff + CNT_W'(in_xfer) - CNT_W'(out_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `MFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `MFE_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result shown right after reset")
   `MFE_ASSERT_NOW(a_no_phantom, clock, reset, rsp_tvalid, cnt_ff != '0, "result with no block in flight")
   `MFE_ASSERT_NOW(a_depth, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH), "more blocks in flight than stages")
   `MFE_ASSERT_NOW(a_flow, clock, reset, rsp_tready || !rsp_tvalid, req_tready, "input blocked while output drains")

endmodule

bind magenta_feistel_encrypt_unit mfe_checker #(.ROUNDS(ROUNDS)) u_mfe_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the MAGENTA Feistel encrypt unit
`timescale 1ns / 1ps

module tb_top;
   import mfe_pkg::*;

   localparam int NUM_ROUNDS   = ROUNDS_DEFAULT;
   localparam int PIPE_LAT     = 6 * NUM_ROUNDS;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_BLOCKS = 130;

   typedef struct packed {
      logic [HALF_W-1:0] right;
      logic [HALF_W-1:0] left;
   } half_pair_type;

   typedef enum int {KEYS_ZERO, KEYS_ONES, KEYS_CHECKER, KEYS_RANDOM} key_mode_type;

   localparam half_pair_type DIRECTED_BLOCKS [10] = '{
      '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
      '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF},
      '{64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [2*HALF_W-1:0]   req_tdata;   // left_half, right_half
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2*HALF_W-1:0]   rsp_tdata;   // left_result, right_result
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [KEY_W-1:0]      csr_wdata;

   logic [7:0]            alpha_pow [256];
   logic [KEY_W-1:0]      round_keys [NUM_KEYS];
   half_pair_type         cipher_q [$];
   int                    failures = 0;
   bit                    quiet = 1'b0;
   int                    stall_left = 0;

   magenta_feistel_encrypt_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // powers of alpha modulo 0x165; the last entry is zero by definition
   initial begin
      logic [8:0] acc;
      acc = 9'd1;
      for (int i = 0; i < 255; i++) begin
         alpha_pow[i] = acc[7:0];
         acc = {acc[7:0], 1'b0};
         if (acc[8]) acc = acc ^ 9'h165;
      end
      alpha_pow[255] = 8'd0;
   end

   function automatic logic [7:0] gf_mix(input logic [7:0] x, input logic [7:0] y);
      return alpha_pow[x ^ alpha_pow[y]];
   endfunction

   function automatic logic [15:0][7:0] butterfly4(input logic [15:0][7:0] v);
      logic [7:0] x;
      logic [7:0] y;
      for (int stride = 8; stride >= 1; stride = stride >> 1) begin
         for (int i = 0; i < 16; i++) begin
            if ((i & stride) == 0) begin
               x = v[i];
               y = v[i + stride];
               v[i] = gf_mix(x, y);
               v[i + stride] = gf_mix(y, x);
            end
         end
      end
      return v;
   endfunction

   function automatic logic [HALF_W-1:0] round_mash(input logic [HALF_W-1:0] r,
                                                    input logic [KEY_W-1:0] k);
      logic [15:0][7:0] w;
      logic [15:0][7:0] t;
      logic [15:0][7:0] s;
      logic [HALF_W-1:0] res;
      for (int j = 0; j < 8; j++) begin
         w[j]     = r[HALF_W-1-8*j -: 8];
         w[8 + j] = k[KEY_W-1-8*j -: 8];
      end
      t = butterfly4(w);
      for (int pass = 0; pass < 2; pass++) begin
         for (int i = 0; i < 8; i++) begin
            s[i]     = w[i] ^ t[2*i];
            s[i + 8] = w[i + 8] ^ t[2*i + 1];
         end
         t = butterfly4(s);
      end
      res = '0;
      for (int i = 0; i < 16; i += 2) res = {res[HALF_W-9:0], t[i]};
      return res;
   endfunction

   function automatic half_pair_type encrypt_block(input half_pair_type blk);
      logic [HALF_W-1:0] l;
      logic [HALF_W-1:0] r;
      logic [HALF_W-1:0] nxt;
      half_pair_type res;
      l = blk.left;
      r = blk.right;
      for (int i = 0; i < NUM_ROUNDS; i++) begin
         nxt = l ^ round_mash(r, round_keys[i % NUM_KEYS]);
         l = r;
         r = nxt;
      end
      res.left = l;
      res.right = r;
      return res;
   endfunction

   // mostly random words, with extremes and single-bit patterns mixed in
   function automatic logic [63:0] pick_word();
      logic [63:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 9))
         0: return 64'h0;
         1: return '1;
         2: return one_hot;
         3: return ~one_hot;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // check results first, then record new transfers, so their order is fixed
   always @(posedge clock) begin
      half_pair_type got;
      half_pair_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (cipher_q.size() == 0) begin
               $error("unexpected result: left_result %h right_result %h", got.left,
                      got.right);
               failures++;
            end else begin
               want = cipher_q.pop_front();
               if (got.left !== want.left) begin
                  $error("left_result: expected %h, got %h", want.left, got.left);
                  failures++;
               end
               if (got.right !== want.right) begin
                  $error("right_result: expected %h, got %h", want.right, got.right);
                  failures++;
               end
            end
         end
         if (csr_wr_en && csr_index < NUM_KEYS) begin
            round_keys[csr_index[KEY_SEL_W-1:0]] = csr_wdata;
         end
         if (req_tvalid && req_tready) cipher_q.push_back(encrypt_block(req_tdata));
      end
   end

   // result side backpressure in bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_block(input logic [63:0] left, input logic [63:0] right);
      half_pair_type blk;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      blk.left = left;
      blk.right = right;
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [KEY_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_keys(input key_mode_type mode);
      logic [KEY_W-1:0] value;
      drain();
      for (int i = 0; i < NUM_KEYS; i++) begin
         case (mode)
            KEYS_ZERO:    value = '0;
            KEYS_ONES:    value = '1;
            KEYS_CHECKER: value = i[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
            default:      value = pick_word();
         endcase
         csr_write(i, value);
      end
      // indexes past the key bank must leave it untouched
      csr_write($urandom_range(NUM_KEYS, 2**CSR_IDX_W - 1), {$urandom, $urandom});
      csr_write(2**CSR_IDX_W - 1, {$urandom, $urandom});
   endtask

   initial begin
      key_mode_type mode;
      for (int i = 0; i < NUM_KEYS; i++) round_keys[i] = '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed blocks under the reset keys, then under all-ones keys
      foreach (DIRECTED_BLOCKS[n]) send_block(DIRECTED_BLOCKS[n].left, DIRECTED_BLOCKS[n].right);
      program_keys(KEYS_ONES);
      foreach (DIRECTED_BLOCKS[n]) send_block(DIRECTED_BLOCKS[n].left, DIRECTED_BLOCKS[n].right);

      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0:       mode = KEYS_ZERO;
            1:       mode = KEYS_CHECKER;
            default: mode = KEYS_RANDOM;
         endcase
         program_keys(mode);
         if (p == RAND_PHASES - 1) quiet = 1'b1;
         repeat (PHASE_BLOCKS) send_block(pick_word(), pick_word());
      end

      req_tvalid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 8) @(posedge clock);
      if (failures == 0) begin
         $display("magenta_feistel_encrypt_unit: match");
      end else begin
         $display("magenta_feistel_encrypt_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("magenta_feistel_encrypt_unit: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/mfe_pkg.sv
src/mfe_key_regs.sv
src/mfe_stage.sv
src/magenta_feistel_encrypt_unit.sv
src/mfe_checker.sv
tb/tb_top.sv
